// ----- src/rbd_pkg.sv -----
// ---------------------------------------------------------------------------
// rbd_pkg: shared types and codes for the readout block deframer
// Holds the request payload structs, the result kind codes and the station
// codes used by the parser, the output buffer, the top level and the test files.
// ---------------------------------------------------------------------------
package rbd_pkg;

    // Field widths fixed by the readout word format
    localparam int WORD_W   = 16;
    localparam int RATE_W   = 10;
    localparam int STN_W    = 4;
    localparam int LEN_W    = 5;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 11;
    localparam int KIND_W   = 2;

    // Result kind codes
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd2;

    // Station codes that open a block
    localparam logic [STN_W-1:0] STN_ADC = 4'd1;
    localparam logic [STN_W-1:0] STN_TDC = 4'd2;
    localparam logic [STN_W-1:0] STN_REG = 4'd3;

    // Reset value of the sampling rate register
    localparam logic [RATE_W-1:0] RATE_RESET = 10'd1;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              buffer_start;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [STN_W-1:0]   station;
        logic [LEN_W-1:0]   block_length;
        logic [POS_W-1:0]   position;
        logic [STN_W-1:0]   channel;
        logic [VALUE_W-1:0] value;
        logic               channel_mismatch;
        logic               report;
        logic               last_in_block;
    } t_out_item;

endpackage

// ----- src/readout_block_deframer.sv -----
// ---------------------------------------------------------------------------
// readout_block_deframer: readout word stream block parser
// Parses 16-bit readout words into headers, block data words and ignored
// words, with ADC channel checking and register-block sampling reports.
//
//   channel | signals                                | payload
//   --------+----------------------------------------+--------------------
//   in      | i_in_valid, o_in_stall, i_in_data      | t_in_item
//   out     | o_out_valid, i_out_stall, o_out_data   | t_out_item
//   cfg     | i_cfg_valid, o_cfg_ready, i_cfg_data   | sample_rate, 10 bit
//
// One request is taken per cycle while o_in_stall is low; its result is buffered.
// The decode is a single combinational pass from the parse state registers
// into a two-entry result buffer.
// o_in_stall rises only when both result slots are occupied.
// Reset (synchronous, active low) clears the parse state, the sampling
// counter and the buffer, and sets sample_rate to 1.
// ---------------------------------------------------------------------------
module readout_block_deframer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  rbd_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output rbd_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [rbd_pkg::RATE_W-1:0] i_cfg_data
);
    import rbd_pkg::*;

    logic [RATE_W-1:0] r_sample_rate;
    logic              full;
    logic              take;
    t_out_item         result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign take        = i_in_valid && !full;

    // Hold the sampling rate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= RATE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sample_rate <= i_cfg_data;
        end
    end

    rbd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_item        (i_in_data),
        .i_sample_rate (r_sample_rate),
        .o_result      (result)
    );

    rbd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

// ----- src/rbd_parser.sv -----
// ---------------------------------------------------------------------------
// rbd_parser: block parse state and word decode
// Decodes one readout word against the current parse state, producing its
// result, and advances the parse state and sampling counter on acceptance.
// ---------------------------------------------------------------------------
module rbd_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  rbd_pkg::t_in_item             i_item,
    input  logic [rbd_pkg::RATE_W-1:0]    i_sample_rate,
    output rbd_pkg::t_out_item            o_result
);
    import rbd_pkg::*;

    logic              r_in_block,  n_in_block;
    logic [STN_W-1:0]  r_station,   n_station;
    logic [LEN_W-1:0]  r_length,    n_length;
    logic [POS_W-1:0]  r_position,  n_position;
    logic              r_report,    n_report;
    logic [RATE_W-1:0] r_phase,     n_phase;

    // effective state after an optional buffer-start clear
    logic              s_in_block;
    logic [STN_W-1:0]  s_station;
    logic [LEN_W-1:0]  s_length;
    logic [POS_W-1:0]  s_position;
    logic              s_report;
    logic [RATE_W-1:0] s_phase;

    logic [STN_W-1:0]   hi4;
    logic [VALUE_W-1:0] val;
    logic [STN_W-1:0]   hdr_station;
    logic [LEN_W-1:0]   hdr_length;
    logic               known_station;
    logic               last;
    logic [RATE_W-1:0]  rate_eff;
    logic [RATE_W:0]    phase_inc;

    // Clear the parse on buffer start before decoding
    always_comb begin
        s_in_block = i_item.buffer_start ? 1'b0 : r_in_block;
        s_station  = i_item.buffer_start ? '0   : r_station;
        s_length   = i_item.buffer_start ? '0   : r_length;
        s_position = i_item.buffer_start ? '0   : r_position;
        s_report   = i_item.buffer_start ? 1'b0 : r_report;
        s_phase    = i_item.buffer_start ? '0   : r_phase;
    end

    // Field extraction
    assign hi4         = i_item.word[14:11];
    assign val         = i_item.word[10:0];
    assign hdr_station = i_item.word[3:0];
    assign hdr_length  = (hi4 == '0) ? LEN_W'(16) : {1'b0, hi4};
    assign known_station = (hdr_station == STN_ADC) || (hdr_station == STN_TDC)
                        || (hdr_station == STN_REG);
    assign last        = ({1'b0, s_position} + LEN_W'(1)) >= s_length;

    // Sampling counter increment with wrap at the configured rate
    assign rate_eff  = (i_sample_rate == '0) ? RATE_RESET : i_sample_rate;
    assign phase_inc = {1'b0, s_phase} + (RATE_W+1)'(1);

    // Decode the word and work out the next parse state
    always_comb begin
        o_result   = '0;
        n_in_block = s_in_block;
        n_station  = s_station;
        n_length   = s_length;
        n_position = s_position;
        n_report   = s_report;
        n_phase    = s_phase;

        if (s_in_block) begin
            o_result.kind          = KIND_DATA;
            o_result.station       = s_station;
            o_result.block_length  = s_length;
            o_result.position      = s_position;
            o_result.value         = val;
            if (s_station == STN_ADC) begin
                o_result.channel          = hi4;
                o_result.channel_mismatch = (hi4 != s_position);
            end
            o_result.report        = s_report;
            o_result.last_in_block = last;
            if (last) begin
                n_in_block = 1'b0;
                n_position = '0;
                if (s_station == STN_REG) begin
                    n_phase = (phase_inc >= {1'b0, rate_eff}) ? '0 : phase_inc[RATE_W-1:0];
                end
            end else begin
                n_position = s_position + POS_W'(1);
            end
        end else if (i_item.word[15]) begin
            o_result.kind         = KIND_HEADER;
            o_result.station      = hdr_station;
            o_result.block_length = hdr_length;
            if (known_station) begin
                n_in_block      = 1'b1;
                n_station       = hdr_station;
                n_length        = hdr_length;
                n_position      = '0;
                n_report        = (s_phase == '0);
                o_result.report = (s_phase == '0);
            end
        end else begin
            o_result.kind = KIND_IGNORED;
        end
    end

    // Hold the parse state, advance it on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_block <= 1'b0;
            r_station  <= '0;
            r_length   <= '0;
            r_position <= '0;
            r_report   <= 1'b0;
            r_phase    <= '0;
        end else if (i_take) begin
            r_in_block <= n_in_block;
            r_station  <= n_station;
            r_length   <= n_length;
            r_position <= n_position;
            r_report   <= n_report;
            r_phase    <= n_phase;
        end
    end

endmodule

// ----- src/rbd_out_buf.sv -----
// ---------------------------------------------------------------------------
// rbd_out_buf: two-entry result register with skid
// Registers each result and keeps a second slot so the input side can still
// take a request while the output side is stalled.
// ---------------------------------------------------------------------------
module rbd_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rbd_pkg::t_out_item i_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output rbd_pkg::t_out_item o_data
);
    import rbd_pkg::*;

    t_out_item  r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       pop;

    assign pop     = (r_count != 2'd0) && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_slot[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop    ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming result
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- test/rbd_checker.sv -----
// ---------------------------------------------------------------------------
// rbd_checker: result predictor and scoreboard for the readout block deframer
// Watches the request, result and configuration channels. Keeps its own copy
// of the parse state and the sampling counter, predicts one result for each
// accepted request and compares every accepted result, field by field,
// against the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module rbd_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  rbd_pkg::t_in_item          i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  rbd_pkg::t_out_item         i_out_data,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [rbd_pkg::RATE_W-1:0] i_cfg_data,
    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_reports
);
    import rbd_pkg::*;

    // Predicted copy of the parser state
    logic              in_blk;
    logic [STN_W-1:0]  blk_station;
    logic [LEN_W-1:0]  blk_len;
    logic [POS_W-1:0]  word_pos;
    logic              blk_report;
    logic [RATE_W-1:0] phase_cnt;
    logic [RATE_W-1:0] rate_setting;

    t_out_item predicted_results [$];
    int        mismatch_count = 0;
    int        checked_count  = 0;
    int        report_count   = 0;

    // Drop the parse state and the sampling counter; the rate is kept
    function automatic void clear_parse_state();
        in_blk      = 1'b0;
        blk_station = '0;
        blk_len     = '0;
        word_pos    = '0;
        blk_report  = 1'b0;
        phase_cnt   = '0;
    endfunction

    // Work out the result of one readout word and advance the parse state
    function automatic t_out_item parse_word(input t_in_item req);
        t_out_item        res;
        logic [3:0]       hi4;
        logic             last;
        logic [RATE_W:0]  next_phase;
        logic [RATE_W:0]  eff_rate;
        res = '0;
        hi4 = req.word[14:11];
        if (req.buffer_start) begin
            clear_parse_state();
        end
        if (in_blk) begin
            // Data word: every word counts, whatever its top bit
            last                 = ({1'b0, word_pos} + 5'd1) >= blk_len;
            res.kind             = KIND_DATA;
            res.station          = blk_station;
            res.block_length     = blk_len;
            res.position         = word_pos;
            res.value            = req.word[10:0];
            res.report           = blk_report;
            res.last_in_block    = last;
            if (blk_station == STN_ADC) begin
                res.channel          = hi4;
                res.channel_mismatch = (hi4 != word_pos);
            end
            if (last) begin
                in_blk   = 1'b0;
                word_pos = '0;
                // Register blocks advance the sampling counter; a rate of 0 acts as 1
                if (blk_station == STN_REG) begin
                    next_phase = {1'b0, phase_cnt} + 1'b1;
                    eff_rate   = (rate_setting == '0) ? 11'd1 : {1'b0, rate_setting};
                    phase_cnt  = (next_phase >= eff_rate) ? '0 : next_phase[RATE_W-1:0];
                end
            end else begin
                word_pos = word_pos + 1'b1;
            end
        end else if (req.word[15]) begin
            // Header: known stations open a block, others are reported only
            res.kind         = KIND_HEADER;
            res.station      = req.word[3:0];
            res.block_length = (hi4 == 4'd0) ? 5'd16 : {1'b0, hi4};
            if (res.station == STN_ADC || res.station == STN_TDC
                    || res.station == STN_REG) begin
                in_blk      = 1'b1;
                blk_station = res.station;
                blk_len     = res.block_length;
                word_pos    = '0;
                blk_report  = (phase_cnt == '0);
                res.report  = blk_report;
            end
        end else begin
            res.kind = KIND_IGNORED;
        end
        return res;
    endfunction

    function automatic string describe(input t_out_item r);
        return $sformatf({"kind %0d station %0d length %0d position %0d channel %0d ",
                          "value %0d chan_mismatch %0d report %0d last %0d"},
                         r.kind, r.station, r.block_length, r.position, r.channel,
                         r.value, r.channel_mismatch, r.report, r.last_in_block);
    endfunction

    // Count a failure; show only the first ten in full
    task automatic report_mismatch(input bit orphan, input t_out_item want,
                                   input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (orphan) begin
                $display("[%0t] result with no request waiting: %s", $time, describe(got));
            end else begin
                $display("[%0t] result differs", $time);
                $display("    expected %s", describe(want));
                $display("    actual   %s", describe(got));
            end
        end
    endtask

    // Sample all three channels at the rising edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            rate_setting = RATE_RESET;
            clear_parse_state();
            predicted_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                rate_setting = i_cfg_data;
            end
            // Check the result first: a request taken now is not answered in the same cycle
            if (i_out_valid && !i_out_stall) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch(1'b1, '0, i_out_data);
                end else begin
                    want = predicted_results.pop_front();
                    checked_count++;
                    if (want.report) begin
                        report_count++;
                    end
                    if (i_out_data.kind !== want.kind
                            || i_out_data.station !== want.station
                            || i_out_data.block_length !== want.block_length
                            || i_out_data.position !== want.position
                            || i_out_data.channel !== want.channel
                            || i_out_data.value !== want.value
                            || i_out_data.channel_mismatch !== want.channel_mismatch
                            || i_out_data.report !== want.report
                            || i_out_data.last_in_block !== want.last_in_block) begin
                        report_mismatch(1'b0, want, i_out_data);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predicted_results.push_back(parse_word(i_in_data));
            end
        end
        o_pending    <= predicted_results.size();
        o_mismatches <= mismatch_count;
        o_checked    <= checked_count;
        o_reports    <= report_count;
    end

endmodule

// ----- test/tb_readout_block_deframer.sv -----
// ---------------------------------------------------------------------------
// tb_readout_block_deframer: stimulus and verdict for the block deframer
// Sends a directed opening of corner-case words, then well-formed blocks with
// random content mixed with ignored words, unknown headers, buffer starts and
// noise, over several sample_rate settings. Both channels idle at random.
// The checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_readout_block_deframer;
    import rbd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 21;
    localparam int NUM_PHASES  = 6;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in_item          in_data;
    logic              out_valid;
    logic              out_stall;
    t_out_item         out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [RATE_W-1:0] cfg_data;

    int                mismatches;
    int                pending;
    int                checked;
    int                reports;
    int                cycles     = 0;
    int                words_sent = 0;
    bit                calm;
    logic [RATE_W-1:0] rate_plan [NUM_PHASES];

    readout_block_deframer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    rbd_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_reports    (reports)
    );

    always #1 clk = ~clk;

    // Stall the result side at random, except in the calm stretch
    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one request, with random idle cycles ahead of it, and hold it until taken
    task automatic send_word(input logic [WORD_W-1:0] w, input logic start);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{word: w, buffer_start: start};
        // Stall only moves at the rising edge, so its value here decides the next edge
        while (in_stall) @(negedge clk);
        @(posedge clk);
        words_sent++;
    endtask

    // Hold off until every predicted result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] rate);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed blocks with random content; the rest ignored words, unknown headers and noise.
    // Ignored words do not count towards the total.
    task automatic send_traffic(input int total);
        int               sent;
        int               pick;
        int               len;
        logic [STN_W-1:0] stn;
        logic [3:0]       hi4;
        logic [15:0]      w;
        sent = 0;
        while (sent < total) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                pick = $urandom_range(0, 99);
                stn  = (pick < 45) ? STN_REG : ((pick < 75) ? STN_ADC : STN_TDC);
                // Short blocks mostly, a few of full length
                if ($urandom_range(0, 9) == 0) begin
                    hi4 = 4'd0;
                end else if ($urandom_range(0, 3) == 0) begin
                    hi4 = 4'($urandom_range(1, 15));
                end else begin
                    hi4 = 4'($urandom_range(1, 4));
                end
                len = (hi4 == 4'd0) ? 16 : int'(hi4);
                send_word({1'b1, hi4, 7'($urandom), stn}, $urandom_range(0, 49) == 0);
                sent++;
                for (int p = 0; p < len; p++) begin
                    w = 16'($urandom);
                    if (stn == STN_ADC && $urandom_range(0, 9) < 6) begin
                        w[14:11] = 4'(p);
                    end
                    send_word(w, $urandom_range(0, 99) == 0);
                    sent++;
                end
            end else if (pick < 85) begin
                send_word({1'b0, 15'($urandom)}, 1'b0);
            end else if (pick < 93) begin
                // Unknown station: 4..15 or 0
                stn = 4'($urandom_range(4, 16));
                send_word({1'b1, 4'($urandom), 7'($urandom), stn}, 1'b0);
                sent++;
            end else begin
                send_word(16'($urandom), $urandom_range(0, 9) == 0);
                sent++;
            end
        end
    endtask

    initial begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        calm      = 1'b0;
        rate_plan = '{10'd2, 10'd1023, 10'd0, 10'd3, 10'd4, RATE_RESET};
        rate_plan[4] = RATE_W'($urandom_range(4, 9));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Ignored words at both extremes
        send_word(16'h0000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        // Unknown stations 0 and 15, lengths 16 and 15
        send_word(16'h8000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        // ADC block of two: matching channel with full value, then a mismatch
        send_word(16'h9001, 1'b0);
        send_word(16'h07FF, 1'b0);
        send_word(16'hA800, 1'b0);
        // TDC block of one whose data word has its top bit set
        send_word(16'h8802, 1'b0);
        send_word(16'hFFFF, 1'b0);
        // Register block of one: reports and advances the counter
        send_word(16'h8803, 1'b0);
        send_word(16'h1234, 1'b0);
        // ADC block of sixteen cut short by a buffer start on a header
        send_word(16'h8001, 1'b0);
        send_word(16'h0001, 1'b0);
        send_word(16'h0802, 1'b0);
        send_word(16'h8001, 1'b1);
        // Buffer start on a plain word inside a block
        send_word(16'h4000, 1'b1);
        // Unknown station opens no block: the next word is ignored
        send_word(16'h8804, 1'b0);
        send_word(16'h0123, 1'b0);
        send_word(16'hF80F, 1'b0);
        send_traffic(100);
        drain();

        // Walk through the rate settings, each from an idle block
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_rate(rate_plan[ph]);
            calm = (ph == 3);
            send_traffic(160);
            drain();
        end
        calm = 1'b0;

        $display("Covered %0d words over %0d sample_rate settings, reset value included.",
                 words_sent, NUM_PHASES + 1);
        $display("Checked %0d results, %0d of them flagged for report.", checked, reports);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/rbd_pkg.sv
src/rbd_parser.sv
src/rbd_out_buf.sv
src/readout_block_deframer.sv
test/rbd_checker.sv
test/tb_readout_block_deframer.sv
